/* hdl/mrpt_pkg.sv */
// shared types and constants for the miller-rabin prime test
`default_nettype none
package mrpt_pkg;
  localparam int unsigned SMALL_COUNT = 12;
  localparam int unsigned PIDX_W = 4;

  function automatic logic [5:0] small_prime(input logic [PIDX_W-1:0] idx);
    logic [5:0] p;
    unique case (idx)
      4'd0: p = 6'd2;
      4'd1: p = 6'd3;
      4'd2: p = 6'd5;
      4'd3: p = 6'd7;
      4'd4: p = 6'd11;
      4'd5: p = 6'd13;
      4'd6: p = 6'd17;
      4'd7: p = 6'd19;
      4'd8: p = 6'd23;
      4'd9: p = 6'd29;
      4'd10: p = 6'd31;
      4'd11: p = 6'd37;
      default: p = 6'd37;
    endcase
    return p;
  endfunction

  // ceil(2^20 / p), gives the exact quotient for 14-bit dividends
  function automatic logic [19:0] small_recip(input logic [PIDX_W-1:0] idx);
    logic [19:0] r;
    unique case (idx)
      4'd0: r = 20'd524288;
      4'd1: r = 20'd349526;
      4'd2: r = 20'd209716;
      4'd3: r = 20'd149797;
      4'd4: r = 20'd95326;
      4'd5: r = 20'd80660;
      4'd6: r = 20'd61681;
      4'd7: r = 20'd55189;
      4'd8: r = 20'd45591;
      4'd9: r = 20'd36158;
      4'd10: r = 20'd33826;
      4'd11: r = 20'd28340;
      default: r = 20'd28340;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mm_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mm_rsp_t;
endpackage
`default_nettype wire

/* hdl/miller_rabin_prime_test.sv */
// miller-rabin prime test top level with trial division and witness sequencer
// trial division first, then per base up to 126 modular products
//   for the power and the squarings
// throughput: one item at a time, set by the bit-serial modular multiplier
// the result waits in an output register while the next item may already start
// reset: synchronous active-low rst_n returns the sequencer to idle
`default_nettype none
module miller_rabin_prime_test #(
  parameter int NUM_BASES = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // candidate
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // prime bit, zero fill
);
  localparam int NB = (NUM_BASES > 12) ? 12 : NUM_BASES;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_TRIAL = 8'b00000010,
    S_SPLIT = 8'b00000100,
    S_BASE  = 8'b00001000,
    S_POW   = 8'b00010000,
    S_CHECK = 8'b00100000,
    S_SQR   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t st_r, st_nxt;
  logic [63:0] n_r, n_nxt, d_r, d_nxt, e_r, e_nxt, acc_r, acc_nxt, sq_r, sq_nxt;
  logic [63:0] x_r, x_nxt;
  logic [6:0]  s_r, s_nxt, r_r, r_nxt;
  logic [3:0]  pi_r, pi_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [3:0]  tb_r, tb_nxt;
  logic        busy_r, busy_nxt;
  logic        res_r, res_nxt;
  logic        flag_r, flag_nxt;
  logic        ov_r, ov_nxt;
  mrpt_pkg::mm_req_t req;
  mrpt_pkg::mm_rsp_t rsp;
  logic [63:0] nm1;
  logic [5:0]  p;
  logic [2:0]  tbi;
  logic [13:0] trial_v;
  logic [33:0] trial_prod;
  logic [5:0]  trial_rem;

  mrpt_modmul u_mm (.clk(clk), .rst_n(rst_n), .m(n_r), .req(req), .rsp(rsp));

  assign nm1 = n_r - 64'd1;
  assign p = mrpt_pkg::small_prime(pi_r);
  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, flag_r};

  // one byte of the candidate per cycle, remainder by reciprocal multiply
  assign tbi = 3'(tb_r - 4'd1);
  assign trial_v = {rem_r, n_r[{tbi, 3'b000} +: 8]};
  assign trial_prod = {20'd0, trial_v} * {14'd0, mrpt_pkg::small_recip(pi_r)};
  assign trial_rem = 6'(trial_v - trial_prod[33:20] * 14'(p));

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; d_nxt = d_r; e_nxt = e_r; acc_nxt = acc_r;
    sq_nxt = sq_r; x_nxt = x_r; s_nxt = s_r; r_nxt = r_r; pi_nxt = pi_r;
    ph_nxt = ph_r; rem_nxt = rem_r; tb_nxt = tb_r; busy_nxt = busy_r;
    res_nxt = res_r; flag_nxt = flag_r; ov_nxt = ov_r;
    req = '0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt = in_tdata;
          pi_nxt = '0;
          rem_nxt = '0;
          tb_nxt = 4'd8;
          if (in_tdata < 64'd2) begin
            res_nxt = 1'b0;
            st_nxt = S_OUT;
          end else st_nxt = S_TRIAL;
        end
      end
      S_TRIAL: begin
        if (tb_r != 4'd0) begin
          rem_nxt = trial_rem;
          tb_nxt = tb_r - 4'd1;
        end else if (rem_r == 6'd0) begin
          res_nxt = (n_r == 64'(p));
          st_nxt = S_OUT;
        end else if (pi_r == 4'(mrpt_pkg::SMALL_COUNT - 1)) begin
          d_nxt = nm1;
          s_nxt = '0;
          st_nxt = S_SPLIT;
        end else begin
          pi_nxt = pi_r + 4'd1;
          rem_nxt = '0;
          tb_nxt = 4'd8;
        end
      end
      S_SPLIT: begin
        if (d_r != 64'd0 && !d_r[0]) begin
          d_nxt = {1'b0, d_r[63:1]};
          s_nxt = s_r + 7'd1;
        end else begin
          pi_nxt = '0;
          st_nxt = S_BASE;
        end
      end
      S_BASE: begin
        if (pi_r == 4'(NB)) begin
          res_nxt = 1'b1;
          st_nxt = S_OUT;
        end else if (64'(mrpt_pkg::small_prime(pi_r)) >= n_r) begin
          pi_nxt = pi_r + 4'd1;
        end else begin
          acc_nxt = 64'd1;
          sq_nxt = 64'(mrpt_pkg::small_prime(pi_r));
          e_nxt = d_r;
          ph_nxt = 2'd0;
          busy_nxt = 1'b0;
          st_nxt = S_POW;
        end
      end
      S_POW: begin
        if (!busy_r) begin
          if (e_r == 64'd0) begin
            x_nxt = acc_r;
            st_nxt = S_CHECK;
          end else if (ph_r == 2'd0 && e_r[0]) begin
            req.start = 1'b1; req.a = acc_r; req.b = sq_r;
            busy_nxt = 1'b1;
          end else begin
            req.start = 1'b1; req.a = sq_r; req.b = sq_r;
            busy_nxt = 1'b1;
            ph_nxt = 2'd1;
          end
        end else if (rsp.done) begin
          busy_nxt = 1'b0;
          if (ph_r == 2'd0) begin
            acc_nxt = rsp.prod;
            ph_nxt = 2'd2;
          end else begin
            sq_nxt = rsp.prod;
            e_nxt = {1'b0, e_r[63:1]};
            ph_nxt = 2'd0;
          end
        end
        if (!busy_r && ph_r == 2'd2) begin
          req.a = sq_r; req.b = sq_r;
        end
      end
      S_CHECK: begin
        if (x_r == 64'd1 || x_r == nm1) begin
          pi_nxt = pi_r + 4'd1;
          st_nxt = S_BASE;
        end else begin
          r_nxt = 7'd1;
          busy_nxt = 1'b0;
          st_nxt = S_SQR;
        end
      end
      S_SQR: begin
        if (!busy_r) begin
          if (r_r >= s_r) begin
            res_nxt = 1'b0;
            st_nxt = S_OUT;
          end else begin
            req.start = 1'b1; req.a = x_r; req.b = x_r;
            busy_nxt = 1'b1;
          end
        end else if (rsp.done) begin
          busy_nxt = 1'b0;
          x_nxt = rsp.prod;
          r_nxt = r_r + 7'd1;
          if (rsp.prod == nm1) begin
            pi_nxt = pi_r + 4'd1;
            st_nxt = S_BASE;
          end
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          flag_nxt = res_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      busy_r <= 1'b0;
      ov_r <= 1'b0;
      pi_r <= '0;
    end else begin
      st_r <= st_nxt;
      busy_r <= busy_nxt;
      ov_r <= ov_nxt;
      pi_r <= pi_nxt;
    end
    n_r <= n_nxt; d_r <= d_nxt; e_r <= e_nxt; acc_r <= acc_nxt; sq_r <= sq_nxt;
    x_r <= x_nxt; s_r <= s_nxt; r_r <= r_nxt; ph_r <= ph_nxt;
    rem_r <= rem_nxt; tb_r <= tb_nxt; res_r <= res_nxt; flag_r <= flag_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  a_small_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata < 64'd2) |=> st_r == S_OUT && !res_r)
    else $error("small candidate");
endmodule
`default_nettype wire

/* hdl/mrpt_modmul.sv */
// bit-serial modular multiplier, one bit of b per cycle
`default_nettype none
module mrpt_modmul (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [63:0]     m,
  input  wire mrpt_pkg::mm_req_t req,
  output mrpt_pkg::mm_rsp_t    rsp
);
  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt;
  logic        done_r, done_nxt;
  logic [64:0] dbl, sum;
  logic [63:0] acc1;

  always_comb begin
    dbl = {1'b0, acc_r} + {1'b0, acc_r};
    acc1 = (dbl >= {1'b0, m}) ? 64'(dbl - {1'b0, m}) : dbl[63:0];
    sum = {1'b0, acc1} + {1'b0, a_r};
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd0;
      acc_nxt = '0;
      a_nxt = req.a;
      b_nxt = req.b;
    end else if (busy_r) begin
      if (b_r[63]) acc_nxt = (sum >= {1'b0, m}) ? 64'(sum - {1'b0, m}) : sum[63:0];
      else acc_nxt = acc1;
      b_nxt = {b_r[62:0], 1'b0};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> !busy_r && $past(busy_r)) else $error("done without run");
  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == 7'd63) |=> rsp.done) else $error("missed done");
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && m != 64'd0 && acc_r < m && a_r < m) |=> (busy_r || rsp.done) |-> acc_r < m)
    else $error("acc out of range");
endmodule
`default_nettype wire
